@@ hdl/pfr_pkg.sv @@
// Package for the page frame replacement block: item types, register indexes,
// policy codes and controller states. Used by the top level and the testbench.
package pfr_pkg;

   typedef struct packed {
      logic [19:0] virt_addr;
      logic [3:0]  process_id;
      logic [31:0] access_time;
      logic [30:0] rand_value;
   } req_type;

   typedef struct packed {
      logic        is_hit;
      logic [5:0]  frame_index;
      logic        did_evict;
      logic [19:0] evicted_page;
      logic [3:0]  evicted_process;
      logic [31:0] stay_time;
   } rsp_type;

   localparam logic [1:0] CSR_PAGE_SIZE    = 2'd0;
   localparam logic [1:0] CSR_FRAME_COUNT  = 2'd1;
   localparam logic [1:0] CSR_REPLACE_MODE = 2'd2;

   localparam logic [1:0] MODE_LRU    = 2'd0;
   localparam logic [1:0] MODE_FIFO   = 2'd1;
   localparam logic [1:0] MODE_RANDOM = 2'd2;

   localparam int PAGE_BITS = 20;
   localparam int PID_BITS  = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_DECIDE,
      ST_WRITE,
      ST_OUT
   } state_type;

endpackage

@@ hdl/pfr_cell.sv @@
// One frame cell of the rotating frame table: a valid bit and a frame entry
// handed on to the neighbor cell on every shift. No package dependencies.
module pfr_cell #(
   parameter int W = 88
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift,
   input  logic         clear,
   input  logic         valid_d,
   input  logic [W-1:0] data_d,
   output logic         valid_q,
   output logic [W-1:0] data_q
);

   logic         valid_ff;
   logic [W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= valid_d;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_d;
      end
   end

   assign valid_q = valid_ff;
   assign data_q  = data_ff;

endmodule

@@ hdl/pfr_divider.sv @@
// Restoring divider, one quotient bit per cycle. Quotient and remainder hold
// until the next start. No package dependencies.
module pfr_divider #(
   parameter int NW = 20,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          busy,
   output logic [NW-1:0] quot,
   output logic [DW-1:0] rem
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [NW-1:0]    q_ff;
   logic [DW-1:0]    r_ff;
   logic [DW-1:0]    d_ff;
   logic [DW:0]      sh;
   logic [DW:0]      diff;
   logic             take;

   always_comb begin
      sh   = {r_ff, q_ff[NW-1]};
      diff = sh - {1'b0, d_ff};
      take = sh >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(NW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= numer;
         r_ff <= '0;
         d_ff <= denom;
      end else if (cnt_ff != '0) begin
         r_ff <= take ? diff[DW-1:0] : sh[DW-1:0];
         q_ff <= {q_ff[NW-2:0], take};
      end
   end

   assign busy = cnt_ff != '0;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

@@ hdl/page_frame_replacement_top.sv @@
// Top level of the page frame replacement block: controller, two serial
// dividers and the rotating row of frame cells. Uses pfr_pkg, pfr_cell and pfr_divider.
//
// One reference at a time is handled. After acceptance the page number and the random
// frame index come from two restoring dividers in parallel, then the frame table
// rotates once through its head cell to search for a hit and a victim, and once more
// to write the chosen frame back. A result still stalled from the item before holds
// the controller until it is taken. Writing frame_count empties the table at once.
// Results wait in an output register, so a new reference may be accepted while the
// last result is not yet taken.
module page_frame_replacement_top #(
   parameter int MAX_FRAMES = 64,
   parameter int TIME_BITS  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pfr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pfr_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   localparam int IW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW  = $clog2(MAX_FRAMES + 1);
   localparam int TB  = TIME_BITS;
   localparam int PB  = pfr_pkg::PAGE_BITS;
   localparam int OB  = pfr_pkg::PID_BITS;
   localparam int W   = 2 * TB + OB + PB;
   localparam logic [IW-1:0] LAST_POS = IW'(MAX_FRAMES - 1);

   function automatic logic [CW-1:0] clamp_count(input logic [6:0] fc);
      logic [CW-1:0] n;
      if (fc == 7'd0) begin
         n = CW'(1);
      end else if (32'(fc) > MAX_FRAMES) begin
         n = CW'(MAX_FRAMES);
      end else begin
         n = CW'(fc);
      end
      return n;
   endfunction

   pfr_pkg::state_type state_ff, state_in;

   logic [15:0]     psize_ff;
   logic [6:0]      fcount_ff;
   logic [1:0]      mode_ff;
   logic [CW-1:0]   n_cur;
   logic            fp_valid_ff;
   logic [IW-1:0]   fp_ff;
   logic [IW-1:0]   pos_ff;
   pfr_pkg::req_type req_ff;
   pfr_pkg::rsp_type res_ff;
   pfr_pkg::rsp_type res_in;
   pfr_pkg::rsp_type rsp_ff;
   logic            rsp_valid_ff;

   logic            found_ff;
   logic [IW-1:0]   hit_idx_ff;
   logic [IW-1:0]   best_ff;
   logic            bv_ff;
   logic [PB-1:0]   bpage_ff;
   logic [OB-1:0]   bown_ff;
   logic [TB-1:0]   bload_ff;
   logic [TB-1:0]   bkey_ff;
   logic            we_ff;
   logic            we_in;
   logic            hitw_ff;
   logic            hitw_in;
   logic [IW-1:0]   slot_ff;
   logic [IW-1:0]   slot_in;

   logic            accept;
   logic            cfg_we;
   logic            clear;
   logic            shift;
   logic            pdiv_busy, rdiv_busy;
   logic [PB-1:0]   page_q;
   logic [15:0]     page_rem;
   logic [30:0]     rand_q;
   logic [CW-1:0]   rand_rem;
   logic [IW-1:0]   rmod;
   logic [15:0]     divisor;
   logic [TB-1:0]   now;

   logic            cv_q [MAX_FRAMES];
   logic [W-1:0]    cd_q [MAX_FRAMES];
   logic            hv;
   logic [W-1:0]    hd;
   logic [PB-1:0]   h_page;
   logic [OB-1:0]   h_own;
   logic [TB-1:0]   h_load;
   logic [TB-1:0]   h_last;
   logic [TB-1:0]   h_key;
   logic            in_range;
   logic            capture;
   logic            wrap_v;
   logic [W-1:0]    wrap_d;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != pfr_pkg::ST_IDLE;
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;
   assign clear     = cfg_we && csr_index == pfr_pkg::CSR_FRAME_COUNT;
   assign n_cur     = clamp_count(fcount_ff);
   assign divisor   = (psize_ff == 16'd0) ? 16'd1 : psize_ff;
   assign now       = TB'(req_ff.access_time);
   assign rmod      = IW'(rand_rem);
   assign shift     = state_ff == pfr_pkg::ST_SCAN || state_ff == pfr_pkg::ST_WRITE;

   pfr_divider #(.NW(PB), .DW(16)) u_page_div (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .numer (req_data.virt_addr),
      .denom (divisor),
      .busy  (pdiv_busy),
      .quot  (page_q),
      .rem   (page_rem)
   );

   pfr_divider #(.NW(31), .DW(CW)) u_rand_div (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .numer (req_data.rand_value),
      .denom (n_cur),
      .busy  (rdiv_busy),
      .quot  (rand_q),
      .rem   (rand_rem)
   );

   assign hv     = cv_q[0];
   assign hd     = cd_q[0];
   assign h_last = hd[TB-1:0];
   assign h_load = hd[2*TB-1:TB];
   assign h_own  = hd[2*TB+OB-1:2*TB];
   assign h_page = hd[W-1:2*TB+OB];
   assign h_key  = (mode_ff == pfr_pkg::MODE_FIFO) ? h_load : h_last;
   assign in_range = {1'b0, pos_ff} < (IW+1)'(n_cur);

   always_comb begin
      capture = 1'b0;
      case (mode_ff)
         pfr_pkg::MODE_LRU, pfr_pkg::MODE_FIFO: begin
            capture = in_range && (pos_ff == '0 || h_key <= bkey_ff);
         end
         pfr_pkg::MODE_RANDOM: begin
            capture = in_range && pos_ff == rmod;
         end
         default: begin
            capture = 1'b0;
         end
      endcase
   end

   always_comb begin
      wrap_v = hv;
      wrap_d = hd;
      if (state_ff == pfr_pkg::ST_WRITE && we_ff && pos_ff == slot_ff) begin
         if (hitw_ff) begin
            wrap_d[TB-1:0] = now;
         end else begin
            wrap_v = 1'b1;
            wrap_d = {page_q, req_ff.process_id, now, now};
         end
      end
   end

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      pfr_cell #(.W(W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .clear   (clear),
         .valid_d ((i == MAX_FRAMES - 1) ? wrap_v : cv_q[(i + 1) % MAX_FRAMES]),
         .data_d  ((i == MAX_FRAMES - 1) ? wrap_d : cd_q[(i + 1) % MAX_FRAMES]),
         .valid_q (cv_q[i]),
         .data_q  (cd_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfr_pkg::ST_IDLE: begin
            if (accept) state_in = pfr_pkg::ST_DIV;
         end
         pfr_pkg::ST_DIV: begin
            if (!pdiv_busy && !rdiv_busy) state_in = pfr_pkg::ST_SCAN;
         end
         pfr_pkg::ST_SCAN: begin
            if (pos_ff == LAST_POS) state_in = pfr_pkg::ST_DECIDE;
         end
         pfr_pkg::ST_DECIDE: begin
            state_in = pfr_pkg::ST_WRITE;
         end
         pfr_pkg::ST_WRITE: begin
            if (pos_ff == LAST_POS) state_in = pfr_pkg::ST_OUT;
         end
         pfr_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = pfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff    <= 16'd16;
         fcount_ff   <= 7'd64;
         mode_ff     <= pfr_pkg::MODE_LRU;
         fp_valid_ff <= 1'b1;
         fp_ff       <= IW'(clamp_count(7'd64) - 1'b1);
      end else begin
         if (cfg_we) begin
            case (csr_index)
               pfr_pkg::CSR_PAGE_SIZE: begin
                  psize_ff <= csr_data;
               end
               pfr_pkg::CSR_FRAME_COUNT: begin
                  fcount_ff   <= csr_data[6:0];
                  fp_valid_ff <= 1'b1;
                  fp_ff       <= IW'(clamp_count(csr_data[6:0]) - 1'b1);
               end
               pfr_pkg::CSR_REPLACE_MODE: begin
                  mode_ff <= csr_data[1:0];
               end
               default: begin
               end
            endcase
         end
         if (state_ff == pfr_pkg::ST_DECIDE && !found_ff && fp_valid_ff) begin
            if (fp_ff == '0) begin
               fp_valid_ff <= 1'b0;
            end else begin
               fp_ff <= fp_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (shift) begin
         pos_ff <= (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      end
   end

   always_comb begin
      res_in  = '0;
      hitw_in = 1'b0;
      we_in   = 1'b1;
      slot_in = slot_ff;
      if (found_ff) begin
         hitw_in            = 1'b1;
         slot_in            = hit_idx_ff;
         res_in.is_hit      = 1'b1;
         res_in.frame_index = 6'(hit_idx_ff);
      end else if (fp_valid_ff) begin
         slot_in            = fp_ff;
         res_in.frame_index = 6'(fp_ff);
      end else if (mode_ff == pfr_pkg::MODE_LRU || mode_ff == pfr_pkg::MODE_FIFO
                   || mode_ff == pfr_pkg::MODE_RANDOM) begin
         slot_in            = best_ff;
         res_in.frame_index = 6'(best_ff);
         if (bv_ff) begin
            res_in.did_evict       = 1'b1;
            res_in.evicted_page    = bpage_ff;
            res_in.evicted_process = bown_ff;
            res_in.stay_time       = 32'(now - bload_ff);
         end
      end else begin
         we_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == pfr_pkg::ST_DIV) begin
         found_ff <= 1'b0;
      end
      if (state_ff == pfr_pkg::ST_SCAN) begin
         if (in_range && hv && h_page == page_q && h_own == req_ff.process_id
             && !found_ff) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= pos_ff;
         end
         if (capture) begin
            best_ff  <= pos_ff;
            bkey_ff  <= h_key;
            bv_ff    <= hv;
            bpage_ff <= h_page;
            bown_ff  <= h_own;
            bload_ff <= h_load;
         end
      end
      if (state_ff == pfr_pkg::ST_DECIDE) begin
         res_ff  <= res_in;
         hitw_ff <= hitw_in;
         we_ff   <= we_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == pfr_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pfr_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfr_pkg::ST_IDLE |-> pos_ff == '0)
      else $error("frame table not aligned while idle");

   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == pfr_pkg::ST_DIV && pdiv_busy && rdiv_busy)
      else $error("dividers not started on accepted item");

   a_fp_range: assert property (@(posedge clock) disable iff (reset)
      fp_valid_ff |-> ({1'b0, fp_ff} < (IW+1)'(n_cur)))
      else $error("free pointer outside active frames");

endmodule

@@ test/page_frame_replacement_top_tb.sv @@
// Testbench for page_frame_replacement_top: directed table then random phases, with a
// frame table predictor checking every result item. Depends on pfr_pkg and the block.
// Free-running clock, bursty sender, patterned receiver stall, single reset.
module page_frame_replacement_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFR = 64;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef struct {
      row_kind_type     kind;
      pfr_pkg::req_type req;
      logic [1:0]       idx;
      logic [15:0]      value;
      bit               typed;
      pfr_pkg::rsp_type rsp;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   pfr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   pfr_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   page_frame_replacement_top dut (.*);

   always #6 clock = ~clock;

   // Predictor state.
   logic [15:0] page_size_q;
   logic [6:0]  frame_count_q;
   logic [1:0]  mode_q;
   bit          fr_valid[NFR];
   logic [19:0] fr_page[NFR];
   logic [3:0]  fr_owner[NFR];
   logic [31:0] fr_load[NFR];
   logic [31:0] fr_use[NFR];
   int          free_ptr;

   pfr_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int n_results = 0;
   int n_hits = 0;
   int n_evicts = 0;
   int n_items = 0;

   function automatic int active_frames();
      if (frame_count_q == 0) return 1;
      if (frame_count_q > NFR) return NFR;
      return frame_count_q;
   endfunction

   function automatic void clear_frames();
      for (int i = 0; i < NFR; i++) begin
         fr_valid[i] = 0;
         fr_page[i] = '0;
         fr_owner[i] = '0;
         fr_load[i] = '0;
         fr_use[i] = '0;
      end
      free_ptr = active_frames() - 1;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [15:0] value);
      case (idx)
         pfr_pkg::CSR_PAGE_SIZE: page_size_q = value;
         pfr_pkg::CSR_FRAME_COUNT: begin
            frame_count_q = value[6:0];
            clear_frames();
         end
         pfr_pkg::CSR_REPLACE_MODE: mode_q = value[1:0];
         default: ;
      endcase
   endfunction

   function automatic pfr_pkg::rsp_type lookup_frame(pfr_pkg::req_type r);
      pfr_pkg::rsp_type o;
      int n;
      int slot;
      logic [19:0] page;
      logic [15:0] divisor;
      o = '0;
      n = active_frames();
      slot = -1;
      divisor = (page_size_q == 0) ? 16'd1 : page_size_q;
      page = r.virt_addr / divisor;
      for (int i = 0; i < n; i++) begin
         if (slot < 0 && fr_valid[i] && fr_page[i] == page && fr_owner[i] == r.process_id)
            slot = i;
      end
      if (slot >= 0) begin
         o.is_hit = 1;
         fr_use[slot] = r.access_time;
      end else begin
         if (free_ptr >= 0 && free_ptr < n) begin
            slot = free_ptr;
            free_ptr--;
         end else begin
            free_ptr = -1;
            if (mode_q == pfr_pkg::MODE_LRU || mode_q == pfr_pkg::MODE_FIFO) begin
               slot = n - 1;
               for (int i = n - 1; i >= 0; i--) begin
                  if (mode_q == pfr_pkg::MODE_LRU ? fr_use[i] < fr_use[slot]
                                                  : fr_load[i] < fr_load[slot])
                     slot = i;
               end
            end else if (mode_q == pfr_pkg::MODE_RANDOM) begin
               slot = r.rand_value % n;
            end
            if (slot >= 0 && fr_valid[slot]) begin
               o.did_evict = 1;
               o.evicted_page = fr_page[slot];
               o.evicted_process = fr_owner[slot];
               o.stay_time = r.access_time - fr_load[slot];
            end
         end
         if (slot >= 0) begin
            fr_valid[slot] = 1;
            fr_page[slot] = page;
            fr_owner[slot] = r.process_id;
            fr_load[slot] = r.access_time;
            fr_use[slot] = r.access_time;
         end
      end
      o.frame_index = (slot >= 0) ? slot[5:0] : 6'd0;
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: result %0d field %s got 0x%0h expected 0x%0h",
               $realtime, n_results, field, got, want);
      errors++;
   endtask

   task automatic field_check(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   // Result monitor.
   always @(posedge clock) begin
      pfr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected", rsp_data[31:0], '0);
         end else begin
            want = expected_rsps.pop_front();
            field_check("is_hit", rsp_data.is_hit, want.is_hit);
            field_check("frame_index", rsp_data.frame_index, want.frame_index);
            field_check("did_evict", rsp_data.did_evict, want.did_evict);
            field_check("evicted_page", rsp_data.evicted_page, want.evicted_page);
            field_check("evicted_process", rsp_data.evicted_process, want.evicted_process);
            field_check("stay_time", rsp_data.stay_time, want.stay_time);
            n_hits += want.is_hit;
            n_evicts += want.did_evict;
         end
         n_results++;
      end
   end

   // Receiver stall pattern: switches at random among four styles.
   int stall_cycle = 0;
   int stall_style = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 256 == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= (stall_cycle % 7) < 3;
         default: rsp_stall <= ($urandom_range(0, 9) == 0);
      endcase
   end

   int burst_left = 0;

   task automatic send_ref(pfr_pkg::req_type r, bit typed, pfr_pkg::rsp_type typed_rsp);
      pfr_pkg::rsp_type p;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 15);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = lookup_frame(r);
      expected_rsps.push_back(typed ? typed_rsp : p);
      n_items++;
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      burst_left = 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      wait_drained();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      csr_valid <= 0;
   endtask

   function automatic row_type item_row(logic [19:0] a, logic [3:0] p, logic [31:0] t,
                                        logic [30:0] rv);
      row_type w;
      w = '{kind: ROW_ITEM, default: 0};
      w.req = '{a, p, t, rv};
      return w;
   endfunction

   function automatic row_type typed_row(logic [19:0] a, logic [3:0] p, logic [31:0] t,
                                         logic [30:0] rv, pfr_pkg::rsp_type o);
      row_type w;
      w = item_row(a, p, t, rv);
      w.typed = 1;
      w.rsp = o;
      return w;
   endfunction

   function automatic row_type csr_row(logic [1:0] idx, logic [15:0] value);
      row_type w;
      w = '{kind: ROW_CSR, default: 0};
      w.idx = idx;
      w.value = value;
      return w;
   endfunction

   row_type rows[$];
   logic [19:0] pool_page[160];
   logic [3:0]  pool_pid[160];

   initial begin
      int pool_n;
      int nfr;
      logic [15:0] ps;
      logic [15:0] div;
      logic [31:0] t_now;
      logic [19:0] max_page;
      logic [31:0] addr;
      int k;
      pfr_pkg::req_type r;
      page_size_q = 16;
      frame_count_q = 64;
      mode_q = pfr_pkg::MODE_LRU;
      clear_frames();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows.push_back(typed_row(20'h0, 4'h0, 32'h0, 31'h0, '{0, 63, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'hF, 4'h0, 32'h1, 31'h0, '{1, 63, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'h0, 4'hF, 32'h2, 31'h0, '{0, 62, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'hFFFFF, 4'hF, 32'hFFFFFFFF, 31'h7FFFFFFF,
                               '{0, 61, 0, 0, 0, 0}));
      rows.push_back(csr_row(pfr_pkg::CSR_FRAME_COUNT, 16'd2));
      rows.push_back(typed_row(20'h10, 4'h1, 32'd10, 31'h0, '{0, 1, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'h20, 4'h1, 32'd20, 31'h0, '{0, 0, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'h1F, 4'h1, 32'd30, 31'h0, '{1, 1, 0, 0, 0, 0}));
      rows.push_back(typed_row(20'h30, 4'h1, 32'd40, 31'h0, '{0, 0, 1, 2, 1, 20}));
      rows.push_back(csr_row(pfr_pkg::CSR_REPLACE_MODE, pfr_pkg::MODE_FIFO));
      rows.push_back(item_row(20'h40, 4'h2, 32'd5, 31'h0));
      rows.push_back(csr_row(pfr_pkg::CSR_REPLACE_MODE, pfr_pkg::MODE_RANDOM));
      rows.push_back(item_row(20'h50, 4'h3, 32'd50, 31'h7FFFFFFF));
      rows.push_back(item_row(20'h60, 4'h3, 32'd60, 31'h0));
      rows.push_back(csr_row(pfr_pkg::CSR_REPLACE_MODE, 16'd3));
      rows.push_back(typed_row(20'h70, 4'h4, 32'd70, 31'h0, '{0, 0, 0, 0, 0, 0}));
      rows.push_back(csr_row(pfr_pkg::CSR_PAGE_SIZE, 16'd0));
      rows.push_back(csr_row(pfr_pkg::CSR_REPLACE_MODE, pfr_pkg::MODE_LRU));
      rows.push_back(item_row(20'h5, 4'h5, 32'd80, 31'h0));
      rows.push_back(csr_row(pfr_pkg::CSR_PAGE_SIZE, 16'hFFFF));
      rows.push_back(item_row(20'hFFFFF, 4'h6, 32'd90, 31'h0));
      rows.push_back(csr_row(pfr_pkg::CSR_FRAME_COUNT, 16'd0));
      rows.push_back(item_row(20'h0, 4'h7, 32'd100, 31'h0));
      rows.push_back(item_row(20'hFFFFF, 4'h7, 32'd100, 31'h0));
      rows.push_back(csr_row(pfr_pkg::CSR_FRAME_COUNT, 16'd127));
      rows.push_back(item_row(20'h12345, 4'hA, 32'd110, 31'h0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) write_csr(rows[i].idx, rows[i].value);
         else send_ref(rows[i].req, rows[i].typed, rows[i].rsp);
      end

      t_now = $urandom;
      for (int ph = 0; ph < 14; ph++) begin
         case ($urandom_range(0, 5))
            0: ps = 1;
            1: ps = 16;
            2: ps = 0;
            3: ps = 16'hFFFF;
            4: ps = 16'($urandom_range(1, 4096));
            default: ps = 16'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 7))
            0: nfr = 1;
            1: nfr = 2;
            2: nfr = 4;
            3: nfr = 64;
            4: nfr = 0;
            5: nfr = $urandom_range(65, 127);
            default: nfr = $urandom_range(1, 64);
         endcase
         write_csr(pfr_pkg::CSR_PAGE_SIZE, ps);
         write_csr(pfr_pkg::CSR_FRAME_COUNT, 16'(nfr));
         write_csr(pfr_pkg::CSR_REPLACE_MODE,
                   ($urandom_range(0, 9) == 0) ? 16'd3 : 16'(ph % 3));
         div = (ps == 0) ? 16'd1 : ps;
         max_page = 20'hFFFFF / div;
         nfr = active_frames();
         pool_n = $urandom_range(1, 2 * nfr + 2);
         for (int i = 0; i < pool_n; i++) begin
            pool_page[i] = 20'($urandom_range(0, max_page));
            pool_pid[i] = 4'($urandom_range(0, 15));
         end
         for (int j = 0; j < 85; j++) begin
            k = $urandom_range(0, pool_n - 1);
            addr = pool_page[k] * div + $urandom_range(0, div - 1);
            r.virt_addr = (addr > 32'hFFFFF) ? 20'hFFFFF : addr[19:0];
            r.process_id = pool_pid[k];
            if ($urandom_range(0, 19) == 0) begin
               r.virt_addr = 20'($urandom);
               r.process_id = 4'($urandom);
            end
            t_now = ($urandom_range(0, 19) == 0) ? $urandom : t_now + $urandom_range(0, 50);
            r.access_time = t_now;
            r.rand_value = 31'($urandom);
            send_ref(r, 0, '0);
         end
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Covered %0d references over directed and 14 random settings:", n_items);
      $display("%0d results, %0d hits, %0d evictions.", n_results, n_hits, n_evicts);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("** page_frame_replacement_top: PASSED **");
      end else begin
         $display("** page_frame_replacement_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("Timeout with %0d results outstanding.", expected_rsps.size());
      $display("** page_frame_replacement_top: FAILED **");
      $finish;
   end
endmodule

@@ page_frame_replacement_top.f @@
hdl/pfr_pkg.sv
hdl/pfr_cell.sv
hdl/pfr_divider.sv
hdl/page_frame_replacement_top.sv
test/page_frame_replacement_top_tb.sv
